>>> sv/rotating_display_line_timer_top_defines.svh
// assertion macros for the checker file
`ifndef ROTATING_DISPLAY_LINE_TIMER_TOP_DEFINES_SVH
`define ROTATING_DISPLAY_LINE_TIMER_TOP_DEFINES_SVH

// antecedent and consequent in the same cycle
`define RDLT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rdlt check failed");

// consequent in the cycle after the antecedent
`define RDLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rdlt check failed");

`endif

>>> sv/rdlt_pkg.sv
package rdlt_pkg;

    localparam int LED_COUNT = 48;
    localparam int MAX_LINES = 256;
    localparam int LINE_AW   = $clog2(MAX_LINES);

    localparam int BITS_W    = 48;
    localparam int LNUM_W    = 8;
    localparam int LCNT_W    = 9;
    localparam int TIME_W    = 32;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 56;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EDGE_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RENDER_EN    = 2'd2;

    localparam logic [TIME_W-1:0] RESET_MIN_GAP = 32'd100000;

    typedef logic [LED_COUNT-1:0] store_word_t;

    typedef struct packed {
        logic tick_take;
        logic load_take;
        logic edge_eval;
        logic div_step;
        logic div_last;
        logic render_take;
        logic out_load;
    } rdlt_cmd_t;

    typedef struct packed {
        logic edge_div;
        logic render_go;
        logic out_free;
    } rdlt_status_t;

    function automatic store_word_t to_store(input logic [BITS_W-1:0] bits);
        logic [63:0] wide;
        wide = 64'(bits);
        return wide[LED_COUNT-1:0];
    endfunction

    function automatic logic [BITS_W-1:0] from_store(input store_word_t w);
        logic [63:0] wide;
        wide = 64'(w);
        return wide[BITS_W-1:0];
    endfunction

endpackage

>>> sv/rotating_display_line_timer_top.sv
// rotating display line timer
// s_ channel: one beat per microsecond tick (s_tuser = 0) or per line store
// load (s_tuser = 1). a load is taken in idle and never gives a result.
// a tick that carries an accepted falling reed edge while the line count is
// nonzero has its line time found by a restoring divider that settles one
// quotient bit per cycle. a tick that renders reads the line store into a
// read register and then moves the line into the m_ output register.
// m_ channel: at most one beat per tick with the line word, its number and a
// revolution start flag. while the receiver stalls, the output register
// holds its beat and the next tick may still be taken; a later result waits
// in the read stage, and s_tready stays low, until the register frees up.
// cfg channel: register writes, taken whenever cfg_ready is high.
// reset (aresetn low, synchronous) clears the timers, the line pointer and
// the registers to their defaults; the line store keeps whatever it held.
module rotating_display_line_timer_top
    import rdlt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // reed_level, load_address, load_bits
    input  logic                 s_tuser,   // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // line_bits, line_number
    output logic                 m_tuser,   // revolution_start
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    rdlt_cmd_t    cmd;
    rdlt_status_t status;

    rdlt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rdlt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> sv/rdlt_ctrl.sv
module rdlt_ctrl
    import rdlt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tuser,
    output logic         s_tready,
    input  rdlt_status_t status,
    output rdlt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_DIV,
        S_RENDER,
        S_READ
    } state_t;

    state_t              state_reg, state_next;
    logic [DIV_CW-1:0]   cnt_reg, cnt_next;
    logic                ready_reg;

    assign s_tready = ready_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (ready_reg && s_tvalid) begin
                    if (s_tuser == CMD_TICK) begin
                        cmd.tick_take = 1'b1;
                        state_next    = S_EDGE;
                    end else begin
                        cmd.load_take = 1'b1;
                    end
                end
            end
            S_EDGE: begin
                cmd.edge_eval = 1'b1;
                cnt_next      = '0;
                state_next    = status.edge_div ? S_DIV : S_RENDER;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_STEPS - 1)) begin
                    cmd.div_last = 1'b1;
                    state_next   = S_RENDER;
                end
            end
            S_RENDER: begin
                if (status.render_go) begin
                    cmd.render_take = 1'b1;
                    state_next      = S_READ;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                // hold the fetched line until the output register frees up
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

endmodule

>>> sv/rdlt_datapath.sv
module rdlt_datapath
    import rdlt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic                 m_tuser,
    input  rdlt_cmd_t            cmd,
    output rdlt_status_t         status
);

    store_word_t line_store [MAX_LINES];

    logic [TIME_W-1:0] time_now_reg;
    logic [TIME_W-1:0] last_edge_reg;
    logic [TIME_W-1:0] line_time_reg;
    logic [TIME_W-1:0] last_render_reg;
    logic              prev_reed_reg;
    logic              reed_reg;
    logic [LCNT_W-1:0] next_line_reg;
    logic [LCNT_W-1:0] line_count_reg;
    logic [TIME_W-1:0] min_gap_reg;
    logic              render_en_reg;
    logic              cfg_ready_reg;

    logic [TIME_W-1:0] quo_reg;
    logic [LCNT_W-1:0] rem_reg;
    store_word_t       rd_data_reg;
    logic [LCNT_W-1:0] idx_reg;

    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic                 m_tuser_reg;

    logic                 s_reed;
    logic [LNUM_W-1:0]    s_addr;
    logic [BITS_W-1:0]    s_bits;
    logic [15:0]          waddr_ext;
    logic                 waddr_ok;

    logic [TIME_W-1:0]    edge_diff;
    logic                 edge_ok;
    logic [TIME_W-1:0]    elapsed;
    logic [LCNT_W-1:0]    idx_sel;
    logic [15:0]          raddr_ext;

    logic [LCNT_W:0]      rem_sh;
    logic                 rem_ge;
    logic [LCNT_W:0]      rem_sub;
    logic [LCNT_W-1:0]    rem_next;
    logic [TIME_W-1:0]    quo_next;
    logic [LCNT_W-1:0]    lc_sat;

    assign s_reed = s_tdata[0];
    assign s_addr = s_tdata[8:1];
    assign s_bits = s_tdata[56:9];

    assign waddr_ext = 16'(s_addr);
    assign waddr_ok  = (32'(s_addr) < 32'(MAX_LINES));

    // falling reed edge far enough from the last accepted one
    assign edge_diff = time_now_reg - last_edge_reg;
    assign edge_ok   = (reed_reg != prev_reed_reg) && !reed_reg && (edge_diff > min_gap_reg);

    assign elapsed = time_now_reg - last_render_reg;

    always_comb begin
        idx_sel = (next_line_reg >= line_count_reg) ? '0 : next_line_reg;
        if (32'(idx_sel) >= 32'(MAX_LINES)) begin
            idx_sel = '0;
        end
    end
    assign raddr_ext = 16'(idx_sel);

    // one restoring divide step: quotient bits shift in at the bottom
    assign rem_sh   = {rem_reg, quo_reg[TIME_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, line_count_reg});
    assign rem_sub  = rem_sh - {1'b0, line_count_reg};
    assign rem_next = rem_ge ? rem_sub[LCNT_W-1:0] : rem_sh[LCNT_W-1:0];
    assign quo_next = {quo_reg[TIME_W-2:0], rem_ge};

    assign lc_sat = (32'(cfg_data[LCNT_W-1:0]) > 32'(MAX_LINES)) ?
                    LCNT_W'(MAX_LINES) : cfg_data[LCNT_W-1:0];

    assign status.edge_div  = edge_ok && (line_count_reg != '0);
    assign status.render_go = render_en_reg && (line_count_reg != '0) &&
                              (elapsed > line_time_reg);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign cfg_ready = cfg_ready_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_take && waddr_ok) begin
            line_store[waddr_ext[LINE_AW-1:0]] <= to_store(s_bits);
        end
        if (cmd.render_take) begin
            rd_data_reg <= line_store[raddr_ext[LINE_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_now_reg    <= '0;
            last_edge_reg   <= '0;
            line_time_reg   <= '0;
            last_render_reg <= '0;
            prev_reed_reg   <= 1'b1;
            next_line_reg   <= '0;
            line_count_reg  <= '0;
            min_gap_reg     <= RESET_MIN_GAP;
            render_en_reg   <= 1'b0;
            cfg_ready_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            cfg_ready_reg <= 1'b1;
            if (cfg_valid && cfg_ready_reg) begin
                case (cfg_index)
                    CFG_LINE_COUNT:   line_count_reg <= lc_sat;
                    CFG_MIN_EDGE_GAP: min_gap_reg    <= cfg_data;
                    CFG_RENDER_EN:    render_en_reg  <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (cmd.tick_take) begin
                time_now_reg <= time_now_reg + 1'b1;
            end
            if (cmd.edge_eval) begin
                prev_reed_reg <= reed_reg;
                if (edge_ok) begin
                    last_edge_reg <= time_now_reg;
                    next_line_reg <= '0;
                end
            end
            if (cmd.div_last) begin
                line_time_reg <= quo_next;
            end
            if (cmd.render_take) begin
                last_render_reg <= time_now_reg;
                next_line_reg   <= idx_sel + 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_take) begin
            reed_reg <= s_reed;
        end
        if (cmd.edge_eval) begin
            quo_reg <= edge_diff;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.render_take) begin
            idx_reg <= idx_sel;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {idx_reg[LNUM_W-1:0], from_store(rd_data_reg)};
            m_tuser_reg <= (idx_reg == '0);
        end
    end

endmodule

>>> sv/rdlt_checker.sv
`include "rotating_display_line_timer_top_defines.svh"

module rdlt_checker
    import rdlt_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    // a stalled result beat keeps its payload
    `RDLT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // revolution start marks line zero and nothing else
    `RDLT_ASSERT_SAME(a_rev_flag, aclk, aresetn, m_tvalid, m_tuser == (m_tdata[55:48] == 8'd0))

    // a tick beat always occupies the block for the following cycle
    `RDLT_ASSERT_NEXT(a_tick_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == CMD_TICK), !s_tready)

    // a new result only appears out of the tick pipeline, never straight from idle
    `RDLT_ASSERT_SAME(a_out_origin, aclk, aresetn, $rose(m_tvalid), !$past(s_tready))

endmodule

bind rotating_display_line_timer_top rdlt_checker u_rdlt_checker (.*);
